@@ rtl/utc_pkg.sv @@
// Shared types, constants and calendar tables of the UTC timestamp parser.
`default_nettype none

package utc_pkg;

  localparam int QUEUE_DEPTH = 2;

  // Characters of the fixed form
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // floor(x / 25) == (x * RECIP_25) >> RECIP_SHIFT for x below 43690
  localparam logic [12:0] RECIP_25    = 13'd5243;
  localparam int          RECIP_SHIFT = 17;

  localparam logic [13:0] YEAR_BIAS   = 14'd400;      // one era, keeps the year positive
  localparam logic [23:0] DAY_OFFSET  = 24'd865566;   // 146097 + 719468 + 1 (day is 1-based)
  localparam logic [16:0] HOUR_SECS   = 17'd3600;
  localparam logic [16:0] MIN_SECS    = 17'd60;
  localparam logic signed [17:0] DAY_SECS = 18'sd86400;

  localparam logic [6:0] MAX_HOUR   = 7'd23;
  localparam logic [6:0] MAX_MINUTE = 7'd59;
  localparam logic [6:0] MAX_SECOND = 7'd60;
  localparam logic [6:0] MONTHS     = 7'd12;

  typedef struct packed {
    logic        fmt_ok;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SPLIT,
    BK_DAYS,
    BK_SCALE,
    BK_OUT
  } back_state_t;

  // Day of a March-based year on which the month starts
  function automatic logic [8:0] month_start(input logic [6:0] m);
    logic [8:0] s;
    unique case (m) inside
      7'd1:    s = 9'd306;
      7'd2:    s = 9'd337;
      7'd3:    s = 9'd0;
      7'd4:    s = 9'd31;
      7'd5:    s = 9'd61;
      7'd6:    s = 9'd92;
      7'd7:    s = 9'd122;
      7'd8:    s = 9'd153;
      7'd9:    s = 9'd184;
      7'd10:   s = 9'd214;
      7'd11:   s = 9'd245;
      7'd12:   s = 9'd275;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] month_days(input logic [6:0] m, input logic leap);
    logic [4:0] n;
    unique case (m) inside
      7'd4, 7'd6, 7'd9, 7'd11: n = 5'd30;
      7'd2:                    n = leap ? 5'd29 : 5'd28;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/utc_front.sv @@
// Character front end: checks the form and accumulates the digit fields.
`default_nettype none

module utc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    char_code,
  input  wire logic          is_last,
  output logic               push_valid,
  input  wire logic          push_ready,
  output utc_pkg::job_t      push_data
);

  localparam logic [4:0] POS_DASH_A  = 5'd4;
  localparam logic [4:0] POS_DASH_B  = 5'd7;
  localparam logic [4:0] POS_T       = 5'd10;
  localparam logic [4:0] POS_COLON_A = 5'd13;
  localparam logic [4:0] POS_COLON_B = 5'd16;
  localparam logic [4:0] POS_DOT     = 5'd19;
  localparam logic [4:0] POS_FRAC    = 5'd21;
  localparam logic [4:0] POS_MAX     = 5'd31;

  logic [4:0]  pos, pos_next;
  logic [13:0] year, year_next;
  logic [6:0]  month, month_next;
  logic [6:0]  day, day_next;
  logic [6:0]  hour, hour_next;
  logic [6:0]  minute, minute_next;
  logic [6:0]  second, second_next;
  logic        err, err_next;

  logic        accept;
  logic        digit;
  logic [3:0]  dval;
  logic        fmt_ok;

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = in_valid && is_last;

  assign digit  = (char_code >= utc_pkg::CH_ZERO) && (char_code <= utc_pkg::CH_NINE);
  assign dval   = char_code[3:0];
  assign fmt_ok = !err && (pos == POS_DOT || pos >= POS_FRAC) && char_code == utc_pkg::CH_Z;

  always_comb begin
    push_data.fmt_ok = fmt_ok;
    push_data.year   = year;
    push_data.month  = month;
    push_data.day    = day;
    push_data.hour   = hour;
    push_data.minute = minute;
    push_data.second = second;
  end

  always_comb begin
    pos_next    = pos;
    year_next   = year;
    month_next  = month;
    day_next    = day;
    hour_next   = hour;
    minute_next = minute;
    second_next = second;
    err_next    = err;
    if (accept) begin
      if (is_last) begin
        pos_next    = '0;
        year_next   = '0;
        month_next  = '0;
        day_next    = '0;
        hour_next   = '0;
        minute_next = '0;
        second_next = '0;
        err_next    = 1'b0;
      end else begin
        case (pos) inside
          POS_DASH_A, POS_DASH_B: begin
            if (char_code != utc_pkg::CH_DASH) err_next = 1'b1;
          end
          POS_T: begin
            if (char_code != utc_pkg::CH_T) err_next = 1'b1;
          end
          POS_COLON_A, POS_COLON_B: begin
            if (char_code != utc_pkg::CH_COLON) err_next = 1'b1;
          end
          POS_DOT: begin
            if (char_code != utc_pkg::CH_DOT) err_next = 1'b1;
          end
          default: begin
            if (!digit) begin
              err_next = 1'b1;
            end else begin
              case (pos) inside
                [5'd0:5'd3]:   year_next   = 14'(year * 14'd10 + 14'(dval));
                [5'd5:5'd6]:   month_next  = 7'(month * 7'd10 + 7'(dval));
                [5'd8:5'd9]:   day_next    = 7'(day * 7'd10 + 7'(dval));
                [5'd11:5'd12]: hour_next   = 7'(hour * 7'd10 + 7'(dval));
                [5'd14:5'd15]: minute_next = 7'(minute * 7'd10 + 7'(dval));
                [5'd17:5'd18]: second_next = 7'(second * 7'd10 + 7'(dval));
                default: ;  // fraction digit, ignored
              endcase
            end
          end
        endcase
        if (pos != POS_MAX) pos_next = pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      year   <= '0;
      month  <= '0;
      day    <= '0;
      hour   <= '0;
      minute <= '0;
      second <= '0;
      err    <= 1'b0;
    end else begin
      pos    <= pos_next;
      year   <= year_next;
      month  <= month_next;
      day    <= day_next;
      hour   <= hour_next;
      minute <= minute_next;
      second <= second_next;
      err    <= err_next;
    end
  end

  // a string's last beat leaves no trace for the next string
  assert property (@(posedge clk) disable iff (rst)
    accept && is_last |=> pos == '0 && !err && year == '0)
    else $error("front state not cleared after last beat");

endmodule

`default_nettype wire

@@ rtl/utc_queue.sv @@
// Short job queue between the character front end and the epoch back end.
`default_nettype none

module utc_queue #(
  parameter int DEPTH = utc_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire utc_pkg::job_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output utc_pkg::job_t      pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  utc_pkg::job_t  mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push, do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

endmodule

`default_nettype wire

@@ rtl/utc_back.sv @@
// Epoch back end: calendar checks and days-from-civil conversion, one job at a time.
`default_nettype none

module utc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              job_valid,
  output logic                   job_pop,
  input  wire utc_pkg::job_t     job_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   valid_res,
  output logic signed [38:0]     epoch_seconds
);

  utc_pkg::back_state_t state, state_next;

  utc_pkg::job_t      job;
  logic [13:0]        y_base;
  logic [23:0]        prod_a;
  logic [23:0]        prod_b;
  logic [16:0]        tod;
  logic signed [23:0] days;
  logic signed [39:0] scaled;
  logic               ok;
  logic               out_load;

  // split step: year shifted to a March start and biased by one era
  logic [13:0]        y_base_next;

  // days step
  logic [6:0]         c100;
  logic [23:0]        pos_sum, neg_sum;

  // scale step
  logic [6:0]         q25;
  logic [11:0]        r25;
  logic               leap;
  logic [4:0]         top_day;
  logic               ok_next;
  logic signed [41:0] day_prod;

  assign y_base_next = 14'(job.year + utc_pkg::YEAR_BIAS - 14'(job.month <= 7'd2));

  assign c100    = prod_a[23:utc_pkg::RECIP_SHIFT];
  assign pos_sum = 24'(y_base) * 24'd365 + 24'(y_base[13:2]) + 24'(c100[6:2])
                 + 24'(utc_pkg::month_start(job.month)) + 24'(job.day);
  assign neg_sum = 24'(c100) + utc_pkg::DAY_OFFSET;

  assign q25     = prod_b[23:utc_pkg::RECIP_SHIFT];
  assign r25     = job.year[13:2] - 12'(q25) * 12'd25;
  assign leap    = (job.year[1:0] == 2'd0) && (r25 != '0 || q25[1:0] == 2'd0);
  assign top_day = utc_pkg::month_days(job.month, leap);
  assign ok_next = job.fmt_ok && job.month != '0 && job.month <= utc_pkg::MONTHS
                && job.day != '0 && job.day <= 7'(top_day)
                && job.hour <= utc_pkg::MAX_HOUR && job.minute <= utc_pkg::MAX_MINUTE
                && job.second <= utc_pkg::MAX_SECOND;
  assign day_prod = days * utc_pkg::DAY_SECS;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      utc_pkg::BK_IDLE:  if (job_valid) state_next = utc_pkg::BK_SPLIT;
      utc_pkg::BK_SPLIT: state_next = utc_pkg::BK_DAYS;
      utc_pkg::BK_DAYS:  state_next = utc_pkg::BK_SCALE;
      utc_pkg::BK_SCALE: state_next = utc_pkg::BK_OUT;
      utc_pkg::BK_OUT:   if (!out_valid || out_ready) state_next = utc_pkg::BK_IDLE;
      default:           state_next = utc_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_pop  = 1'b0;
    out_load = 1'b0;
    unique case (state)
      utc_pkg::BK_IDLE: job_pop  = job_valid;
      utc_pkg::BK_OUT:  out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= utc_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) job <= job_data;
    if (state == utc_pkg::BK_SPLIT) begin
      y_base <= y_base_next;
      prod_a <= 24'(y_base_next[13:2]) * 24'(utc_pkg::RECIP_25);
      tod    <= 17'(job.hour) * utc_pkg::HOUR_SECS + 17'(job.minute) * utc_pkg::MIN_SECS
              + 17'(job.second);
    end
    if (state == utc_pkg::BK_DAYS) begin
      days   <= $signed(pos_sum - neg_sum);
      prod_b <= 24'(job.year[13:2]) * 24'(utc_pkg::RECIP_25);
    end
    if (state == utc_pkg::BK_SCALE) begin
      ok     <= ok_next;
      scaled <= day_prod[39:0];
    end
    if (out_load) begin
      valid_res     <= ok;
      epoch_seconds <= ok ? $signed(39'(scaled + $signed({23'd0, tod}))) : '0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(valid_res) && $stable(epoch_seconds))
    else $error("result beat changed while waiting");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> epoch_seconds == '0)
    else $error("invalid result carries a nonzero epoch");

  assert property (@(posedge clk) disable iff (rst)
    state == utc_pkg::BK_OUT && !out_valid |=> out_valid && state == utc_pkg::BK_IDLE)
    else $error("finished job not moved to the output register");

endmodule

`default_nettype wire

@@ rtl/utc_timestamp_to_epoch_parser_core.sv @@
// Top level of the UTC timestamp to Unix epoch parser.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    char_code[7:0], is_last
//   out      out  out_valid/out_ready  valid_res, epoch_seconds[38:0] signed
//
// One character beat per cycle; the front end stalls only while the job queue is full.
// The back end takes one timestamp at a time through its steps: pop, split, days, scale, output load.
// After the last beat the job passes the queue and then these steps before out_valid rises.
// Strings may follow each other back to back while fewer than QUEUE_DEPTH jobs wait.
// Synchronous reset clears position, accumulators, queue pointers, back-end state and out_valid.
`default_nettype none

module utc_timestamp_to_epoch_parser_core #(
  parameter int QUEUE_DEPTH = utc_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        char_code,
  input  wire logic              is_last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   valid_res,
  output logic signed [38:0]     epoch_seconds
);

  logic          push_valid, push_ready;
  utc_pkg::job_t push_data;
  logic          job_valid, job_pop;
  utc_pkg::job_t job_data;

  utc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .is_last    (is_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  utc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (job_valid),
    .pop_ready  (job_pop),
    .pop_data   (job_data)
  );

  utc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (job_valid),
    .job_pop       (job_pop),
    .job_data      (job_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .valid_res     (valid_res),
    .epoch_seconds (epoch_seconds)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_utc_timestamp_to_epoch_parser_core.sv @@
// Self-checking testbench for the UTC timestamp to epoch parser core.
`timescale 1ns / 1ps

module tb_utc_timestamp_to_epoch_parser_core;

  localparam int     ITEM_TARGET     = 1850;
  localparam int     CALM_TAIL_FROM  = 1550;  // no idling past this many characters
  localparam int     HOLD_CYCLES     = 300;
  localparam int     SETTLE_CYCLES   = 12;
  localparam int     QUIET_LIMIT     = 3000;
  localparam int     PRESSURE_STAMPS = 6;
  localparam longint ERA_DAYS        = 146097;
  localparam longint CIVIL_SHIFT     = 719468;
  localparam longint SECS_PER_DAY    = 86400;

  typedef struct packed {
    logic               ok;
    logic signed [38:0] secs;
  } epoch_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         char_code = 8'd0;
  logic               is_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               valid_res;
  logic signed [38:0] epoch_seconds;

  // parser state mirrored on the accepted beats
  logic [4:0]  pos_q;
  logic [13:0] yr_q;
  logic [6:0]  mon_q, day_q, hr_q, mnt_q, sec_q;
  bit          fmt_bad;

  epoch_result_t epoch_due_q[$];
  epoch_result_t head_result;
  logic [7:0]    stamp_chars[$];

  string row_text[$];
  bit    row_known[$];
  bit    row_ok[$];
  longint row_secs[$];

  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned chars_sent = 0;
  int unsigned stamps_sent = 0;
  int unsigned results_seen = 0;
  int unsigned valid_seen = 0;
  int unsigned mismatches = 0;

  utc_timestamp_to_epoch_parser_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .valid_res    (valid_res),
    .epoch_seconds(epoch_seconds)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int days_in_month(input int m, input bit leap);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return leap ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // days since 1970-01-01, March-based year so the leap day falls at the end
  function automatic longint days_from_civil(input longint y, input longint m, input longint d);
    longint era, yoe, mp, doy, doe;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * ERA_DAYS + doe - CIVIL_SHIFT;
  endfunction

  function automatic void clear_parser();
    pos_q   = '0;
    yr_q    = '0;
    mon_q   = '0;
    day_q   = '0;
    hr_q    = '0;
    mnt_q   = '0;
    sec_q   = '0;
    fmt_bad = 1'b0;
  endfunction

  task automatic step_parser(input logic [7:0] c, input bit last, output bit has_res,
                             output bit ok, output logic signed [38:0] secs);
    bit         is_digit;
    bit         leap;
    logic [6:0] dv;
    int         yr;
    longint     total;
    has_res  = 1'b0;
    ok       = 1'b0;
    secs     = '0;
    is_digit = (c >= utc_pkg::CH_ZERO) && (c <= utc_pkg::CH_NINE);
    dv       = is_digit ? 7'(c - utc_pkg::CH_ZERO) : 7'd0;
    if (!last) begin
      case (pos_q)
        5'd4, 5'd7:   if (c != utc_pkg::CH_DASH) fmt_bad = 1'b1;
        5'd10:        if (c != utc_pkg::CH_T) fmt_bad = 1'b1;
        5'd13, 5'd16: if (c != utc_pkg::CH_COLON) fmt_bad = 1'b1;
        5'd19:        if (c != utc_pkg::CH_DOT) fmt_bad = 1'b1;
        default: begin
          if (!is_digit) fmt_bad = 1'b1;
          else if (pos_q <= 5'd3) yr_q = 14'(yr_q * 10 + dv);
          else if (pos_q <= 5'd6) mon_q = 7'(mon_q * 10 + dv);
          else if (pos_q <= 5'd9) day_q = 7'(day_q * 10 + dv);
          else if (pos_q <= 5'd12) hr_q = 7'(hr_q * 10 + dv);
          else if (pos_q <= 5'd15) mnt_q = 7'(mnt_q * 10 + dv);
          else if (pos_q <= 5'd18) sec_q = 7'(sec_q * 10 + dv);
          // fraction digits only need to be digits
        end
      endcase
      if (pos_q != 5'd31) pos_q = pos_q + 5'd1;
    end else begin
      has_res = 1'b1;
      ok = !fmt_bad && (pos_q == 5'd19 || pos_q >= 5'd21) && (c == utc_pkg::CH_Z);
      if (ok) begin
        yr   = int'(yr_q);
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        ok   = (mon_q >= 7'd1) && (mon_q <= utc_pkg::MONTHS) && (day_q >= 7'd1) &&
               (int'(day_q) <= days_in_month(int'(mon_q), leap)) &&
               (hr_q <= utc_pkg::MAX_HOUR) && (mnt_q <= utc_pkg::MAX_MINUTE) &&
               (sec_q <= utc_pkg::MAX_SECOND);
      end
      if (ok) begin
        total = days_from_civil(yr_q, mon_q, day_q) * SECS_PER_DAY +
                longint'(hr_q) * 3600 + longint'(mnt_q) * 60 + longint'(sec_q);
        secs  = total[38:0];
      end
      clear_parser();
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic send_beat(input logic [7:0] c, input bit last);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    is_last   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  // known rows carry a hand-written result in place of the predicted one
  task automatic send_stamp(input bit known, input bit ok, input longint secs);
    bit                 has_res, res_ok, at_end;
    logic signed [38:0] res_secs;
    for (int i = 0; i < stamp_chars.size(); i++) begin
      at_end = (i == stamp_chars.size() - 1);
      send_beat(stamp_chars[i], at_end);
      step_parser(stamp_chars[i], at_end, has_res, res_ok, res_secs);
      if (has_res) begin
        if (known) begin
          res_ok   = ok;
          res_secs = secs[38:0];
        end
        epoch_due_q.push_back('{ok: res_ok, secs: res_secs});
      end
    end
    stamps_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (epoch_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_digits(input int value, input int ndig);
    int scale;
    scale = 1;
    repeat (ndig - 1) scale *= 10;
    repeat (ndig) begin
      stamp_chars.push_back(8'(utc_pkg::CH_ZERO + (value / scale) % 10));
      scale /= 10;
    end
  endtask

  task automatic add_row(input string text, input bit known, input bit ok, input longint secs);
    row_text.push_back(text);
    row_known.push_back(known);
    row_ok.push_back(ok);
    row_secs.push_back(secs);
  endtask

  // mostly well-formed stamps with random fields, plus broken and noise strings
  task automatic make_stamp(input bit clean);
    int kind, yr, mon, day, hr, mnt, sec, nfrac, idx;
    stamp_chars.delete();
    kind = clean ? 0 : $urandom_range(0, 99);
    if (kind >= 95) begin
      repeat ($urandom_range(1, 40)) stamp_chars.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 5))
      0:       yr = 400 * $urandom_range(0, 24) + 100 * $urandom_range(0, 1);
      1:       yr = $urandom_range(0, 1) ? 9999 : 0;
      default: yr = $urandom_range(0, 9999);
    endcase
    mon = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    day = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
    if (mon == 2 && $urandom_range(0, 1)) day = $urandom_range(28, 30);
    hr  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
    mnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    sec = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
    push_digits(yr, 4);
    stamp_chars.push_back(utc_pkg::CH_DASH);
    push_digits(mon, 2);
    stamp_chars.push_back(utc_pkg::CH_DASH);
    push_digits(day, 2);
    stamp_chars.push_back(utc_pkg::CH_T);
    push_digits(hr, 2);
    stamp_chars.push_back(utc_pkg::CH_COLON);
    push_digits(mnt, 2);
    stamp_chars.push_back(utc_pkg::CH_COLON);
    push_digits(sec, 2);
    case ($urandom_range(0, 3))
      2:       nfrac = $urandom_range(1, 4);
      3:       nfrac = $urandom_range(8, 20);  // at twelve or more digits this runs the position count into saturation
      default: nfrac = 0;
    endcase
    if (nfrac > 0) begin
      stamp_chars.push_back(utc_pkg::CH_DOT);
      repeat (nfrac) stamp_chars.push_back(8'(utc_pkg::CH_ZERO + $urandom_range(0, 9)));
    end
    stamp_chars.push_back(utc_pkg::CH_Z);
    if (kind >= 70 && kind < 85) begin
      idx = $urandom_range(0, stamp_chars.size() - 1);
      stamp_chars[idx] = 8'($urandom_range(0, 255));
    end else if (kind >= 85 && kind < 92) begin
      idx = $urandom_range(1, stamp_chars.size() - 1);
      while (stamp_chars.size() > idx) void'(stamp_chars.pop_back());
    end else if (kind >= 92) begin
      while (stamp_chars.size() > 19) void'(stamp_chars.pop_back());
      stamp_chars.push_back(utc_pkg::CH_DOT);
      stamp_chars.push_back(utc_pkg::CH_Z);
    end
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  <= 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (epoch_due_q.size() == 0) begin
        report_mismatch("result beat with no timestamp pending", epoch_seconds, 0);
      end else begin
        head_result = epoch_due_q.pop_front();
        if (valid_res !== head_result.ok)
          report_mismatch("valid_res", valid_res, head_result.ok);
        if (epoch_seconds !== head_result.secs)
          report_mismatch("epoch_seconds", epoch_seconds, head_result.secs);
        results_seen++;
        if (valid_res) valid_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TIMEOUT: no beat moved for %0d cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    string text;
    clear_parser();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    add_row("1970-01-01T00:00:00Z", 1, 1, 0);
    add_row("0000-01-01T00:00:00Z", 1, 1, -64'sd62167219200);
    add_row("9999-12-31T23:59:60Z", 1, 1, 64'sd253402300800);
    add_row("2000-02-29T12:34:56.5Z", 0, 0, 0);
    add_row("2024-02-29T23:59:60Z", 0, 0, 0);
    add_row("1900-02-29T00:00:00Z", 1, 0, 0);
    add_row("2024-13-01T00:00:00Z", 1, 0, 0);
    add_row("2024-04-31T00:00:00Z", 1, 0, 0);
    add_row("2024-00-00T00:00:00Z", 1, 0, 0);
    add_row("2024-01-01T24:60:61Z", 1, 0, 0);
    add_row("2024-01-01T23:59:59", 1, 0, 0);
    add_row("2024-01-01T00:00:00.Z", 1, 0, 0);
    add_row("1969-12-31T23:59:59.123456789012345678Z", 0, 0, 0);
    add_row("2024-06-15T08:30:00.1234567890123a5Z", 1, 0, 0);
    add_row("2024-06-15T08:30:00X", 1, 0, 0);
    add_row("2024/06-15T08:30:00Z", 1, 0, 0);
    add_row("2024-06-\2655T08:30:00Z", 1, 0, 0);
    add_row("Z", 1, 0, 0);

    for (int r = 0; r < row_text.size(); r++) begin
      text = row_text[r];
      stamp_chars.delete();
      for (int i = 0; i < text.len(); i++) stamp_chars.push_back(text[i]);
      send_stamp(row_known[r], row_ok[r], row_secs[r]);
    end
    drain_results();

    // hold the result side while whole stamps keep coming, so the input backs up
    hold_req <= 1'b1;
    repeat (PRESSURE_STAMPS) begin
      make_stamp(1'b1);
      send_stamp(1'b0, 1'b0, 0);
    end
    drain_results();

    while (chars_sent < ITEM_TARGET) begin
      if (chars_sent >= CALM_TAIL_FROM && idle_on) idle_on <= 1'b0;
      make_stamp(1'b0);
      send_stamp(1'b0, 1'b0, 0);
    end
    drain_results();

    $display("Sent %0d strings (%0d characters); checked %0d results, %0d of them valid.",
             stamps_sent, chars_sent, results_seen, valid_seen);
    $display("Covered range ends, calendar and format faults, long fractions, full stall.");
    if (mismatches == 0 && epoch_due_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/utc_pkg.sv
rtl/utc_front.sv
rtl/utc_queue.sv
rtl/utc_back.sv
rtl/utc_timestamp_to_epoch_parser_core.sv
tb/sv/tb_utc_timestamp_to_epoch_parser_core.sv
